// ===== hdl/cfr_pkg.sv =====
// shared constants, types and crc fold function for the byte-stuffing framer
`timescale 1ns / 1ps

package cfr_pkg;

  // command codes carried on the input tuser
  localparam logic CMD_PAYLOAD = 1'b0;
  localparam logic CMD_CLOSE   = 1'b1;

  // configuration register indexes
  localparam logic REG_POLY = 1'b0;
  localparam logic REG_INIT = 1'b1;

  // configuration reset values
  localparam logic [15:0] CRC_POLY_RESET = 16'h8005;
  localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

  // stuffing bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;

  // frame length saturation point
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // field widths
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;
  localparam int LEN_W  = 16;

  // next encoded byte offered by the encoder to the output stage
  typedef struct packed {
    logic             valid;
    logic [BYTE_W-1:0] data;
    logic             last;
  } head_t;

  // msb-first crc fold of one byte, eight steps
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc_in,
                                                input logic [CRC_W-1:0] poly,
                                                input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] crc;
    crc = crc_in;
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[CRC_W-1] ^ data[BYTE_W-1-k]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== hdl/cfr_encoder.sv =====
// input stage: crc update and stuffing of one item into a short byte queue
`timescale 1ns / 1ps

module cfr_encoder
  import cfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // payload_byte
  input  logic              s_tuser,   // cmd
  input  logic [CRC_W-1:0]  crc_polynomial,
  input  logic [CRC_W-1:0]  crc_initial,
  output head_t             head,
  input  logic              pop
);

  logic [CRC_W-1:0]         crc_reg;
  logic [3:0][BYTE_W-1:0]   pend_bytes;
  logic [2:0]               pend_cnt;
  logic                     pend_close;

  logic                     accept;
  logic [3:0][BYTE_W-1:0]   new_bytes;
  logic [2:0]               new_cnt;
  logic [CRC_W-1:0]         crc_next;
  logic [BYTE_W-1:0]        lo_byte;
  logic [BYTE_W-1:0]        hi_byte;
  logic [1:0][BYTE_W-1:0]   st_a;
  logic [1:0][BYTE_W-1:0]   st_b;
  logic                     dbl_a;
  logic                     dbl_b;

  // room for a new item when the queue is empty or drains its last byte now
  assign s_tready = (pend_cnt == 3'd0) || ((pend_cnt == 3'd1) && pop);
  assign accept   = s_tvalid && s_tready;

  // stuffing of the first and second raw byte of the item
  assign lo_byte = (s_tuser == CMD_CLOSE) ? crc_reg[7:0] : s_tdata;
  assign hi_byte = crc_reg[15:8];

  always_comb begin
    dbl_a = 1'b1;
    st_a  = {ESC_FLAG, ESC_BYTE};
    if (lo_byte == FLAG_BYTE) begin
      st_a = {ESC_FLAG, ESC_BYTE};
    end else if (lo_byte == ESC_BYTE) begin
      st_a = {ESC_ESC, ESC_BYTE};
    end else begin
      dbl_a = 1'b0;
      st_a  = {8'h00, lo_byte};
    end
  end

  always_comb begin
    dbl_b = 1'b1;
    st_b  = {ESC_FLAG, ESC_BYTE};
    if (hi_byte == FLAG_BYTE) begin
      st_b = {ESC_FLAG, ESC_BYTE};
    end else if (hi_byte == ESC_BYTE) begin
      st_b = {ESC_ESC, ESC_BYTE};
    end else begin
      dbl_b = 1'b0;
      st_b  = {8'h00, hi_byte};
    end
  end

  // byte list and crc for the incoming item
  always_comb begin
    if (s_tuser == CMD_CLOSE) begin
      crc_next = crc_initial;
      if (dbl_a) begin
        new_bytes = {st_b[1], st_b[0], st_a[1], st_a[0]};
      end else begin
        new_bytes = {8'h00, st_b[1], st_b[0], st_a[0]};
      end
      new_cnt = 3'd2 + {2'b00, dbl_a} + {2'b00, dbl_b};
    end else begin
      crc_next  = crc_fold(crc_reg, crc_polynomial, s_tdata);
      new_bytes = {16'h0000, st_a[1], st_a[0]};
      new_cnt   = 3'd1 + {2'b00, dbl_a};
    end
  end

  // crc register
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CRC_INIT_RESET;
    end else if (accept) begin
      crc_reg <= crc_next;
    end
  end

  // byte queue: load on accept, shift down on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 3'd0;
    end else if (accept) begin
      pend_cnt <= new_cnt;
    end else if (pop) begin
      pend_cnt <= pend_cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_bytes <= new_bytes;
      pend_close <= (s_tuser == CMD_CLOSE);
    end else if (pop) begin
      pend_bytes <= {8'h00, pend_bytes[3], pend_bytes[2], pend_bytes[1]};
    end
  end

  // queue head toward the output stage
  assign head.valid = (pend_cnt != 3'd0);
  assign head.data  = pend_bytes[0];
  assign head.last  = pend_close && (pend_cnt == 3'd1);

endmodule

// ===== hdl/cfr_output.sv =====
// output stage: result register and stuffed frame length counter
`timescale 1ns / 1ps

module cfr_output
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  head_t       head,
  output logic        pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte, frame_length
  output logic        m_tlast    // frame_end
);

  logic                  out_valid;
  logic [BYTE_W-1:0]     out_byte;
  logic                  out_end;
  logic [LEN_W-1:0]      out_len;
  logic [LEN_W-1:0]      byte_count;
  logic [LEN_W-1:0]      len_inc;

  // take the head whenever the result register is free or being drained
  assign pop     = head.valid && (!out_valid || m_tready);
  assign len_inc = (byte_count == LEN_MAX) ? byte_count : byte_count + 16'd1;

  // result valid and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      byte_count <= '0;
    end else if (pop) begin
      out_valid  <= 1'b1;
      byte_count <= head.last ? '0 : len_inc;
    end else if (m_tready) begin
      out_valid  <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte <= head.data;
      out_end  <= head.last;
      out_len  <= len_inc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_len, out_byte};
  assign m_tlast  = out_end;

endmodule

// ===== hdl/crc16_byte_stuffing_framer.sv =====
// top level of the crc-16 byte-stuffing framer with its configuration registers
//
//  channel | direction | fields
//  s_*     | in        | tdata[7:0] payload_byte, tuser cmd (0 payload, 1 close)
//  m_*     | out       | tdata[7:0] out_byte, tdata[23:8] frame_length, tlast frame_end
//  cfg_*   | in        | cfg_index 0 crc_polynomial, 1 crc_initial; cfg_data 16 bits
//
//  one result byte leaves per cycle while bytes are queued and m_tready is high;
//  an item is taken in the cycle its last queued byte moves to the result register,
//  so a plain byte queues one byte, a stuffed byte two and a close two to four
//  the crc of a byte is folded in the cycle it is accepted
//  reset is synchronous: queue and result register empty, crc = 0xffff
//  a stall on m_tready holds the result and the queue; input waits behind them
`timescale 1ns / 1ps

module crc16_byte_stuffing_framer
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // payload_byte
  input  logic        s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte, frame_length
  output logic        m_tlast,   // frame_end
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [CRC_W-1:0] crc_polynomial;
  logic [CRC_W-1:0] crc_initial;
  head_t            head;
  logic             pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= CRC_POLY_RESET;
      crc_initial    <= CRC_INIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLY: crc_polynomial <= cfg_data;
        REG_INIT: crc_initial    <= cfg_data;
        default:  ;
      endcase
    end
  end

  // crc and stuffing
  cfr_encoder u_encoder (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .crc_polynomial (crc_polynomial),
    .crc_initial    (crc_initial),
    .head           (head),
    .pop            (pop)
  );

  // result register and length count
  cfr_output u_output (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
